// ===== sv/ota_pkg.sv =====
package ota_pkg;

    // Field widths fixed by the item format
    localparam int ID_W            = 5;
    localparam int COUNT_W         = 16;
    localparam int CFG_W           = 5;
    localparam int MAX_RACERS_DEF  = 16;
    localparam int ENTRY_COUNT_RST = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command codes
    localparam logic CMD_OVERTAKE = 1'b0;
    localparam logic CMD_FINISH   = 1'b1;

    // Result list kinds
    localparam logic KIND_ORDER = 1'b0;
    localparam logic KIND_RANK  = 1'b1;

    // One list entry: id in the upper bits, count in the lower bits
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // True when entry a goes ahead of entry b in the ranking
    function automatic logic ranks_before(entry_t a, entry_t b);
        logic res;
        if (a.count != b.count)
        begin
            res = (a.count > b.count);
        end
        else
        begin
            res = (a.id < b.id);
        end
        return res;
    endfunction

endpackage

// ===== sv/ota_if.sv =====
// Input channel: one command per transfer
interface ota_in_if
    import ota_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            command;
    logic [ID_W-1:0] racer_id;

    modport source (output valid, output command, output racer_id, input ready);
    modport sink   (input valid, input command, input racer_id, output ready);
endinterface

// Output channel: one list entry per transfer
interface ota_out_if
    import ota_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               list_kind;
    logic [ID_W-1:0]    racer_id_out;
    logic [COUNT_W-1:0] overtakes;
    logic               last;

    modport source (output valid, output list_kind, output racer_id_out,
                    output overtakes, output last, input ready);
    modport sink   (input valid, input list_kind, input racer_id_out,
                    input overtakes, input last, output ready);
endinterface

// ===== sv/ota_vram.sv =====
// Synchronous RAM with per-entry valid bits, one write and two read ports.
// An entry not written since the last clear reads back with rv low.
module ota_vram
    import ota_pkg::*;
#(
    parameter int DEPTH = MAX_RACERS_DEF,
    parameter int WIDTH = ENTRY_W,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr,
    input  logic             we,
    input  logic [AW-1:0]    wa,
    input  logic [WIDTH-1:0] wd,
    input  logic [AW-1:0]    ra0,
    output logic [WIDTH-1:0] rd0,
    output logic             rv0,
    output logic [AW-1:0]    rq0,
    input  logic [AW-1:0]    ra1,
    output logic [WIDTH-1:0] rd1,
    output logic             rv1,
    output logic [AW-1:0]    rq1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd0_reg;
    logic [WIDTH-1:0] rd1_reg;
    logic             rv0_reg;
    logic             rv1_reg;
    logic [AW-1:0]    rq0_reg;
    logic [AW-1:0]    rq1_reg;

    // Storage array and read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd0_reg <= mem[ra0];
        rd1_reg <= mem[ra1];
        rq0_reg <= ra0;
        rq1_reg <= ra1;
    end

    // Valid bits, cleared all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv0_reg   <= 1'b0;
            rv1_reg   <= 1'b0;
        end
        else
        begin
            rv0_reg <= valid_reg[ra0] && !clr;
            rv1_reg <= valid_reg[ra1] && !clr;
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[wa] <= 1'b1;
            end
        end
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;
    assign rv0 = rv0_reg;
    assign rv1 = rv1_reg;
    assign rq0 = rq0_reg;
    assign rq1 = rq1_reg;

endmodule

// ===== sv/ota_ram.sv =====
// Plain synchronous RAM, one write and one read port
module ota_ram
    import ota_pkg::*;
#(
    parameter int DEPTH = MAX_RACERS_DEF,
    parameter int WIDTH = ENTRY_W,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wa,
    input  logic [WIDTH-1:0] wd,
    input  logic [AW-1:0]    ra,
    output logic [WIDTH-1:0] rd
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    assign rd = rd_reg;

endmodule

// ===== sv/overtake_list_with_ranking_top.sv =====
// Overtake list with ranking.
// in_ch carries a command and a racer id. An overtake moves the named racer
// one place ahead and bumps its count (saturating); a racer already at the
// front, id 0 and ids above entry_count are ignored. A finish streams on
// out_ch first the current order (list_kind 0), then the ranking by count,
// highest first, lower id on ties (list_kind 1); each run ends with last.
// The list then returns to ids 1..N in order with zero counts.
// cfg_we/cfg_wdata set entry_count (clamped to 1..MAX_RACERS) and also
// restart the list; write only while the block is idle.
// An overtake first looks up the racer's position from its id; a front
// racer ends there. Otherwise both entries are read, then two write-backs
// go through the single write port of each memory. A finish reads the
// list in order while it insertion-sorts a copy in the scratch memory,
// then reads the ranking out; in_ch is not ready during that work.
// Results sit in an output register; a stall on out_ch holds the sequencer
// without losing an item, and a new command is taken while the last result
// still waits. Reset restores entry_count 16 and the initial list at once
// through the valid bits; no clearing pass is needed.
module overtake_list_with_ranking_top
    import ota_pkg::*;
#(
    parameter int MAX_RACERS = MAX_RACERS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ota_in_if.sink           in_ch,
    ota_out_if.source        out_ch
);

    localparam int AW = $clog2(MAX_RACERS);
    localparam int NW = $clog2(MAX_RACERS + 1);
    localparam int RESET_N = (ENTRY_COUNT_RST > MAX_RACERS) ? MAX_RACERS
                                                             : ENTRY_COUNT_RST;

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOC      = 4'd1;
    localparam logic [3:0] S_SWAP1    = 4'd2;
    localparam logic [3:0] S_SWAP2    = 4'd3;
    localparam logic [3:0] S_ORD_RD   = 4'd4;
    localparam logic [3:0] S_ORD_EMIT = 4'd5;
    localparam logic [3:0] S_INS_CMP  = 4'd6;
    localparam logic [3:0] S_INS_PUT  = 4'd7;
    localparam logic [3:0] S_RNK_RD   = 4'd8;
    localparam logic [3:0] S_RNK_EMIT = 4'd9;

    logic [3:0]      state_reg, state_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   j_reg, j_next;
    entry_t          tmp_reg, tmp_next;
    entry_t          e_reg, e_next;

    logic               out_valid_reg, out_valid_next;
    logic               kind_reg, kind_next;
    entry_t             res_reg, res_next;
    logic               last_reg, last_next;

    // Position memory: position -> entry
    logic          p_we;
    logic [AW-1:0] p_wa, p_ra0, p_ra1, p_rq0, p_rq1;
    entry_t        p_wd, p_rd0, p_rd1, p_e0, p_e1;
    logic          p_rv0, p_rv1;

    // Location memory: id-1 -> position
    logic          l_we;
    logic [AW-1:0] l_wa, l_wd, l_ra, l_rd, l_rq, l_pos;
    logic          l_rv;

    // Scratch memory for the ranking
    logic          s_we;
    logic [AW-1:0] s_wa, s_ra;
    entry_t        s_wd, s_rd;

    logic          list_clr;
    logic          out_free;
    logic          idx_last;
    logic          id_known;
    logic [NW-1:0] cfg_n;

    ota_vram #(.DEPTH(MAX_RACERS), .WIDTH(ENTRY_W)) u_pos_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (list_clr),
        .we    (p_we),
        .wa    (p_wa),
        .wd    (p_wd),
        .ra0   (p_ra0),
        .rd0   (p_rd0),
        .rv0   (p_rv0),
        .rq0   (p_rq0),
        .ra1   (p_ra1),
        .rd1   (p_rd1),
        .rv1   (p_rv1),
        .rq1   (p_rq1)
    );

    ota_vram #(.DEPTH(MAX_RACERS), .WIDTH(AW)) u_loc_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (list_clr),
        .we    (l_we),
        .wa    (l_wa),
        .wd    (l_wd),
        .ra0   (l_ra),
        .rd0   (l_rd),
        .rv0   (l_rv),
        .rq0   (l_rq),
        .ra1   ('0),
        .rd1   (),
        .rv1   (),
        .rq1   ()
    );

    ota_ram #(.DEPTH(MAX_RACERS), .WIDTH(ENTRY_W)) u_scratch (
        .clk (clk),
        .we  (s_we),
        .wa  (s_wa),
        .wd  (s_wd),
        .ra  (s_ra),
        .rd  (s_rd)
    );

    // Entries never written since the last restart read as the initial list
    always_comb
    begin
        p_e0 = p_rd0;
        p_e1 = p_rd1;
        if (!p_rv0)
        begin
            p_e0.id    = ID_W'(32'(p_rq0) + 1);
            p_e0.count = '0;
        end
        if (!p_rv1)
        begin
            p_e1.id    = ID_W'(32'(p_rq1) + 1);
            p_e1.count = '0;
        end
        l_pos = l_rv ? l_rd : l_rq;
    end

    // Register value clamped to 1..MAX_RACERS
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            cfg_n = NW'(1);
        end
        else if (32'(cfg_wdata) > MAX_RACERS)
        begin
            cfg_n = NW'(MAX_RACERS);
        end
        else
        begin
            cfg_n = NW'(cfg_wdata);
        end
    end

    assign out_free = !out_valid_reg || out_ch.ready;
    assign idx_last = (32'(idx_reg) + 1 == 32'(n_reg));
    assign id_known = (in_ch.racer_id != '0) && (32'(in_ch.racer_id) <= 32'(n_reg));
    assign in_ch.ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = cfg_we ? cfg_n : n_reg;
        id_next        = id_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        tmp_next       = tmp_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        kind_next      = kind_reg;
        res_next       = res_reg;
        last_next      = last_reg;
        list_clr       = cfg_we;

        p_we  = 1'b0;
        p_wa  = pos_reg;
        p_wd  = tmp_reg;
        p_ra0 = idx_reg;
        p_ra1 = '0;
        l_we  = 1'b0;
        l_wa  = '0;
        l_wd  = pos_reg;
        l_ra  = AW'(in_ch.racer_id - ID_W'(1));
        s_we  = 1'b0;
        s_wa  = j_reg;
        s_wd  = e_reg;
        s_ra  = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    id_next = in_ch.racer_id;
                    if (in_ch.command == CMD_FINISH)
                    begin
                        idx_next   = '0;
                        state_next = S_ORD_RD;
                    end
                    else if (id_known)
                    begin
                        state_next = S_LOC;
                    end
                end
            end
            S_LOC:
            begin
                // Racer at the front stays where it is
                if (l_pos == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    pos_next   = l_pos;
                    p_ra0      = l_pos;
                    p_ra1      = l_pos - AW'(1);
                    state_next = S_SWAP1;
                end
            end
            S_SWAP1:
            begin
                p_we     = 1'b1;
                p_wa     = pos_reg - AW'(1);
                p_wd.id  = id_reg;
                p_wd.count = (p_e0.count == COUNT_MAX) ? p_e0.count
                                                       : p_e0.count + COUNT_W'(1);
                l_we     = 1'b1;
                l_wa     = AW'(id_reg - ID_W'(1));
                l_wd     = pos_reg - AW'(1);
                tmp_next = p_e1;
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                p_we = 1'b1;
                l_we = 1'b1;
                l_wa = AW'(tmp_reg.id - ID_W'(1));
                state_next = S_IDLE;
            end
            S_ORD_RD:
            begin
                state_next = S_ORD_EMIT;
            end
            S_ORD_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ORDER;
                    res_next       = p_e0;
                    last_next      = idx_last;
                    e_next         = p_e0;
                    j_next         = idx_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        s_ra       = idx_reg - AW'(1);
                        state_next = S_INS_CMP;
                    end
                end
            end
            S_INS_CMP:
            begin
                if (ranks_before(e_reg, s_rd))
                begin
                    // Shift the scratch entry one place down
                    s_we   = 1'b1;
                    s_wd   = s_rd;
                    j_next = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        s_ra = j_reg - AW'(2);
                    end
                end
                else
                begin
                    s_we = 1'b1;
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = S_RNK_RD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_ORD_RD;
                    end
                end
            end
            S_INS_PUT:
            begin
                s_we = 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_RNK_RD;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_ORD_RD;
                end
            end
            S_RNK_RD:
            begin
                state_next = S_RNK_EMIT;
            end
            S_RNK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_RANK;
                    res_next       = s_rd;
                    last_next      = idx_last;
                    if (idx_last)
                    begin
                        list_clr   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RNK_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= NW'(RESET_N);
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            j_reg         <= j_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        pos_reg  <= pos_next;
        tmp_reg  <= tmp_next;
        e_reg    <= e_next;
        kind_reg <= kind_next;
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.list_kind    = kind_reg;
    assign out_ch.racer_id_out = res_reg.id;
    assign out_ch.overtakes    = res_reg.count;
    assign out_ch.last         = last_reg;

endmodule

// ===== sv/ota_checker.sv =====
// Port-level checks for the overtake list
module ota_checker
    import ota_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_command,
    input logic            out_valid,
    input logic            out_ready,
    input logic [ID_W-1:0] out_id
);

    // A pending result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A finish occupies the block for the next cycle at least
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_command == CMD_FINISH) |=> !in_ready)
        else $error("input ready right after a finish transfer");

    // A finish never shows a result in the following cycle from an empty output
    a_finish_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_command == CMD_FINISH) && !out_valid
        |=> !out_valid)
        else $error("result appeared too early after finish");

    // Racer ids in results are never zero
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_id != '0))
        else $error("result carries racer id zero");

endmodule

bind overtake_list_with_ranking_top ota_checker u_ota_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_id     (out_ch.racer_id_out)
);

// ===== dv/standings_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the config port, keeps its own copy of the
// racer list, and compares every list entry that leaves the block.
module standings_checker
    import ota_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ota_in_if                in_ch,
    ota_out_if               out_ch,
    output int               fail_count,
    output int               pending,
    output int               entries_checked
);

    typedef struct packed {
        logic               kind;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
        logic               last;
    } standing_t;

    // Predicted list: ids and counts by position
    logic [ID_W-1:0]    grid_ids    [MAX_RACERS_DEF];
    logic [COUNT_W-1:0] grid_counts [MAX_RACERS_DEF];
    int                 field_size;

    // Entries expected on out_ch, oldest first
    standing_t          due_standings[$];
    standing_t          got;
    standing_t          want;

    // Back to ids 1..N in order, all counts zero
    function automatic void restart_grid();
        for (int i = 0; i < MAX_RACERS_DEF; i++)
        begin
            grid_ids[i]    = ID_W'(i + 1);
            grid_counts[i] = '0;
        end
    endfunction

    // Racer moves one place ahead; front racer and unknown ids do nothing
    function automatic void apply_overtake(logic [ID_W-1:0] id);
        int                 pos;
        logic [ID_W-1:0]    tid;
        logic [COUNT_W-1:0] tc;
        pos = -1;
        if (id == 0 || int'(id) > field_size)
        begin
            return;
        end
        for (int i = 0; i < field_size; i++)
        begin
            if (pos < 0 && grid_ids[i] == id)
            begin
                pos = i;
            end
        end
        if (pos > 0)
        begin
            tid = grid_ids[pos];
            tc  = (grid_counts[pos] == COUNT_MAX) ? COUNT_MAX : grid_counts[pos] + 1'b1;
            grid_ids[pos]        = grid_ids[pos-1];
            grid_counts[pos]     = grid_counts[pos-1];
            grid_ids[pos-1]      = tid;
            grid_counts[pos-1]   = tc;
        end
    endfunction

    // Order run, then ranking run (count descending, lower id on ties)
    function automatic void queue_finish();
        logic [ID_W-1:0]    r_ids  [MAX_RACERS_DEF];
        logic [COUNT_W-1:0] r_cnts [MAX_RACERS_DEF];
        logic [ID_W-1:0]    tid;
        logic [COUNT_W-1:0] tc;
        standing_t          s;
        int                 j;
        for (int i = 0; i < field_size; i++)
        begin
            s.kind  = KIND_ORDER;
            s.id    = grid_ids[i];
            s.count = grid_counts[i];
            s.last  = (i == field_size - 1);
            due_standings.push_back(s);
            r_ids[i]  = grid_ids[i];
            r_cnts[i] = grid_counts[i];
        end
        for (int i = 1; i < field_size; i++)
        begin
            j = i;
            while (j > 0 && ((r_cnts[j] > r_cnts[j-1]) ||
                             (r_cnts[j] == r_cnts[j-1] && r_ids[j] < r_ids[j-1])))
            begin
                tid         = r_ids[j];
                tc          = r_cnts[j];
                r_ids[j]    = r_ids[j-1];
                r_cnts[j]   = r_cnts[j-1];
                r_ids[j-1]  = tid;
                r_cnts[j-1] = tc;
                j--;
            end
        end
        for (int i = 0; i < field_size; i++)
        begin
            s.kind  = KIND_RANK;
            s.id    = r_ids[i];
            s.count = r_cnts[i];
            s.last  = (i == field_size - 1);
            due_standings.push_back(s);
        end
        restart_grid();
    endfunction

    // Sample on the rising edge: compare results, then follow config and commands
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_size      = ENTRY_COUNT_RST;
            restart_grid();
            due_standings.delete();
            fail_count      = 0;
            pending         = 0;
            entries_checked = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.list_kind, out_ch.racer_id_out, out_ch.overtakes, out_ch.last};
                if (due_standings.size() == 0)
                begin
                    $display("%0t: unexpected entry: expected none, got kind %0d id %0d count %0d last %0d",
                             $time, got.kind, got.id, got.count, got.last);
                    fail_count++;
                end
                else
                begin
                    want = due_standings.pop_front();
                    entries_checked++;
                    if (got !== want)
                    begin
                        $display("%0t: entry mismatch: expected kind %0d id %0d count %0d last %0d, got kind %0d id %0d count %0d last %0d",
                                 $time, want.kind, want.id, want.count, want.last,
                                 got.kind, got.id, got.count, got.last);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_wdata == 0)
                begin
                    field_size = 1;
                end
                else if (int'(cfg_wdata) > MAX_RACERS_DEF)
                begin
                    field_size = MAX_RACERS_DEF;
                end
                else
                begin
                    field_size = int'(cfg_wdata);
                end
                restart_grid();
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.command == CMD_FINISH)
                begin
                    queue_finish();
                end
                else
                begin
                    apply_overtake(in_ch.racer_id);
                end
            end
            pending = due_standings.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ota_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TRADE_ROUNDS   = 4;
    localparam int PHASE_CMDS     = 36;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    ota_in_if  in_ch ();
    ota_out_if out_ch ();

    int fail_count;
    int pending;
    int entries_checked;
    int orders_sent;
    int size_now;
    int stall_idle;
    int hold_req;
    int wd_idle;

    overtake_list_with_ranking_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    standings_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .fail_count      (fail_count),
        .pending         (pending),
        .entries_checked (entries_checked)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: ends the run after too many cycles with no transfer
    initial
    begin
        wd_idle = 0;
        while (wd_idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            begin
                wd_idle = 0;
            end
            else
            begin
                wd_idle++;
            end
        end
        $display("%0t: watchdog expired, %0d entries still due", $time, pending);
        $display("overtake_list_with_ranking_top test failed");
        $finish;
    end

    // Result side: random ready with runs, short and long stalls, one long hold-off
    initial
    begin
        int run_left;
        int r;
        logic rdy;
        out_ch.ready = 1'b0;
        run_left     = 0;
        rdy          = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_req = 0;
                rdy      = 1'b0;
                run_left = HOLD_CYCLES;
            end
            else if (run_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (stall_idle != 0 || r < 55)
                begin
                    rdy      = 1'b1;
                    run_left = $urandom_range(1, 12);
                end
                else if (r < 90)
                begin
                    rdy      = 1'b0;
                    run_left = $urandom_range(1, 3);
                end
                else
                begin
                    rdy      = 1'b0;
                    run_left = $urandom_range(10, 40);
                end
            end
            out_ch.ready <= rdy;
            run_left--;
        end
    end

    // One command transfer, preceded by a random gap; valid stays high on zero gap
    task automatic send_cmd(input logic cmd, input logic [ID_W-1:0] id);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (stall_idle != 0 || r < 70)
        begin
            gap = 0;
        end
        else if (r < 92)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.command  <= cmd;
        in_ch.racer_id <= id;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        orders_sent++;
    endtask

    // Drain all due entries, then let the block settle
    task automatic settle(input int extra);
        in_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (extra) @(negedge clk);
    endtask

    // Write entry_count; only called once the block is idle
    task automatic set_entry_count(input int v);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (v == 0)
        begin
            size_now = 1;
        end
        else if (v > MAX_RACERS_DEF)
        begin
            size_now = MAX_RACERS_DEF;
        end
        else
        begin
            size_now = v;
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int sizes [8];
        int r;
        logic [ID_W-1:0] id;
        sizes          = '{3, 16, 1, 17, 2, 9, 0, 5};
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.command  = CMD_OVERTAKE;
        in_ch.racer_id = '0;
        orders_sent    = 0;
        stall_idle     = 0;
        hold_req       = 0;
        size_now       = ENTRY_COUNT_RST;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: front racer, unknown ids, back of the list, ties
        send_cmd(CMD_OVERTAKE, 5'd1);
        send_cmd(CMD_OVERTAKE, 5'd0);
        send_cmd(CMD_OVERTAKE, 5'd17);
        send_cmd(CMD_OVERTAKE, 5'd31);
        send_cmd(CMD_OVERTAKE, 5'd16);
        send_cmd(CMD_OVERTAKE, 5'd16);
        send_cmd(CMD_OVERTAKE, 5'd15);
        send_cmd(CMD_OVERTAKE, 5'd2);
        send_cmd(CMD_OVERTAKE, 5'd2);
        send_cmd(CMD_FINISH, 5'd31);
        send_cmd(CMD_FINISH, 5'd0);
        settle(16);
        // Clamp low: single racer list
        set_entry_count(0);
        send_cmd(CMD_OVERTAKE, 5'd1);
        send_cmd(CMD_OVERTAKE, 5'd2);
        send_cmd(CMD_FINISH, 5'd1);
        settle(16);
        // Clamp high
        set_entry_count(31);
        send_cmd(CMD_OVERTAKE, 5'd9);
        send_cmd(CMD_FINISH, 5'd21);
        settle(16);

        // Two racers trade places back to back a few times
        set_entry_count(2);
        stall_idle = 1;
        for (int k = 0; k < TRADE_ROUNDS; k++)
        begin
            send_cmd(CMD_OVERTAKE, 5'd2);
            send_cmd(CMD_OVERTAKE, 5'd1);
        end
        send_cmd(CMD_FINISH, 5'd0);
        stall_idle = 0;
        settle(16);

        // Random phases over several list sizes
        for (int p = 0; p < 8; p++)
        begin
            set_entry_count((p == 6) ? $urandom_range(0, 31) : sizes[p]);
            stall_idle = (p == 4);
            if (p == 1)
            begin
                // long hold-off on the result side while commands keep coming
                hold_req = 1;
                send_cmd(CMD_FINISH, 5'($urandom));
            end
            for (int k = 0; k < PHASE_CMDS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    send_cmd(CMD_FINISH, 5'($urandom));
                end
                else
                begin
                    if (r < 82)
                    begin
                        id = ID_W'($urandom_range(1, size_now));
                    end
                    else
                    begin
                        id = ID_W'($urandom_range(0, 31));
                    end
                    send_cmd(CMD_OVERTAKE, id);
                end
            end
            send_cmd(CMD_FINISH, 5'($urandom));
            stall_idle = 0;
            settle(16);
        end

        settle(20);
        $display("Covered %0d commands over list sizes 1 to 16, clamped writes and trades;",
                 orders_sent);
        $display("%0d list entries compared, %0d mismatches.", entries_checked, fail_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("overtake_list_with_ranking_top test passed");
        end
        else
        begin
            $display("overtake_list_with_ranking_top test failed");
        end
        $finish;
    end

endmodule
